// ----- sv/heightmap_bilinear_sampler_core_macros.svh -----
// Assertion macros for the heightmap bilinear sampler core.
// Taken in by the top level; expects signals clk and rst_n in scope.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define HBS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/hbs_pkg.sv -----
// Shared constants and helpers for the heightmap bilinear sampler.
// Used by every module of the block but the queue; depends on nothing.
package hbs_pkg;

  localparam int DEF_MAX_COLS       = 256;
  localparam int DEF_MAX_ROWS       = 256;
  localparam int DEF_SENTINEL_SLOTS = 4;
  localparam int DEF_FRAC_BITS      = 8;

  localparam int DATA_W     = 32;
  localparam int COORD_W    = 18;
  localparam int CELL_IDX_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_W      = 32;
  localparam int SENT_MAX   = 4;
  localparam int QDEPTH     = 2;

  // Heights above 50000 m (Q24.8) count as no-data when sentinels are active.
  localparam logic signed [DATA_W-1:0] NODATA_LIMIT = 32'sd12800000;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_NEAREST = 2'd1;
  localparam logic [1:0] ACT_BILIN   = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODATA_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NODATA_0     = 3'd3;

  // Width of one queued request: kind, value, four addresses, four weights.
  function automatic int entry_w(input int aw, input int ww);
    entry_w = 2 + DATA_W + 4 * aw + 4 * ww;
  endfunction

endpackage

// ----- sv/hbs_queue.sv -----
// Small first-in first-out queue between the front and back of the sampler.
// Depends on nothing but its parameters.
module hbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               push_data,
  input  logic                           pop,
  output logic                           full,
  output logic                           not_empty,
  output logic [WIDTH-1:0]               head,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNTW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = store_r[rd_ptr_r];
  assign count     = count_r;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNTW'(1);
        2'b01:   count_r <= count_r - CNTW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- sv/hbs_front.sv -----
// Front end: classifies an accepted request, clamps the query position and
// works out corner addresses and weights. Depends on hbs_pkg.
module hbs_front #(
  parameter int MAX_COLS  = hbs_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS  = hbs_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = hbs_pkg::DEF_FRAC_BITS
) (
  input  logic                                     take,
  input  logic [1:0]                               in_action,
  input  logic [hbs_pkg::CELL_IDX_W-1:0]           in_cell_col,
  input  logic [hbs_pkg::CELL_IDX_W-1:0]           in_cell_row,
  input  logic signed [hbs_pkg::DATA_W-1:0]        in_cell_value,
  input  logic signed [hbs_pkg::COORD_W-1:0]       in_col_coord,
  input  logic signed [hbs_pkg::COORD_W-1:0]       in_row_coord,
  input  logic [$clog2(MAX_COLS+1)-1:0]            eff_w,
  input  logic [$clog2(MAX_ROWS+1)-1:0]            eff_h,
  output logic                                     push,
  output logic [hbs_pkg::entry_w($clog2(MAX_COLS*MAX_ROWS), 2*FRAC_BITS+1)-1:0] entry
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int WCW  = $clog2(MAX_COLS+1);
  localparam int WRW  = $clog2(MAX_ROWS+1);
  localparam int AW   = $clog2(MAX_COLS*MAX_ROWS);
  localparam int WW   = 2*FRAC_BITS+1;
  localparam int CPW  = WCW + FRAC_BITS;
  localparam int RPW  = WRW + FRAC_BITS;
  localparam int F    = FRAC_BITS;
  localparam int PW   = hbs_pkg::POS_W;
  localparam int CIW  = hbs_pkg::CELL_IDX_W;
  localparam int XW   = ((CIW > CW) ? CIW : CW) + 1;
  localparam int YW   = ((CIW > RW) ? CIW : RW) + 1;

  logic signed [PW-1:0] cpos, ctop, rpos, rtop;
  logic [CPW-1:0]       cp;
  logic [RPW-1:0]       rp;
  logic [CPW:0]         cn_sum;
  logic [RPW:0]         rn_sum;
  logic [WCW:0]         cn;
  logic [WRW:0]         rn;
  logic [CW-1:0]        c_near, c0, c1;
  logic [RW-1:0]        r_near, r0, r1;
  logic [WCW-1:0]       c0_w, c0_inc;
  logic [WRW-1:0]       r0_w, r0_inc;
  logic [F-1:0]         fx, fy;
  logic [F:0]           sfx, sfy;
  logic [WW-1:0]        w00, w10, w01, w11;
  logic [AW-1:0]        a00, a10, a01, a11, a_near, a_wr;
  logic                 wr_ok;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    addr_of = AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  always_comb begin
    cpos = PW'(in_col_coord);
    rpos = PW'(in_row_coord);
    ctop = $signed(PW'(eff_w - WCW'(1))) <<< F;
    rtop = $signed(PW'(eff_h - WRW'(1))) <<< F;
    if (cpos < 0)         cp = '0;
    else if (cpos > ctop) cp = ctop[CPW-1:0];
    else                  cp = cpos[CPW-1:0];
    if (rpos < 0)         rp = '0;
    else if (rpos > rtop) rp = rtop[RPW-1:0];
    else                  rp = rpos[RPW-1:0];

    // Nearest: round half up, then keep inside the grid in use.
    cn_sum = (CPW+1)'(cp) + (CPW+1)'(1 << (F-1));
    rn_sum = (RPW+1)'(rp) + (RPW+1)'(1 << (F-1));
    cn = cn_sum[CPW:F];
    rn = rn_sum[RPW:F];
    if (cn > (WCW+1)'(eff_w - WCW'(1))) c_near = CW'(eff_w - WCW'(1));
    else                                c_near = cn[CW-1:0];
    if (rn > (WRW+1)'(eff_h - WRW'(1))) r_near = RW'(eff_h - WRW'(1));
    else                                r_near = rn[RW-1:0];

    // Bilinear: corner indices and fraction weights.
    c0_w   = cp[CPW-1:F];
    r0_w   = rp[RPW-1:F];
    c0_inc = c0_w + WCW'(1);
    r0_inc = r0_w + WRW'(1);
    c0 = c0_w[CW-1:0];
    r0 = r0_w[RW-1:0];
    c1 = (c0_inc < eff_w) ? c0_inc[CW-1:0] : CW'(eff_w - WCW'(1));
    r1 = (r0_inc < eff_h) ? r0_inc[RW-1:0] : RW'(eff_h - WRW'(1));
    fx  = cp[F-1:0];
    fy  = rp[F-1:0];
    sfx = (F+1)'(1 << F) - (F+1)'(fx);
    sfy = (F+1)'(1 << F) - (F+1)'(fy);
    w00 = WW'(sfx * sfy);
    w10 = WW'((F+1)'(fx) * sfy);
    w01 = WW'(sfx * (F+1)'(fy));
    w11 = WW'((F+1)'(fx) * (F+1)'(fy));

    a00    = addr_of(r0, c0);
    a10    = addr_of(r0, c1);
    a01    = addr_of(r1, c0);
    a11    = addr_of(r1, c1);
    a_near = addr_of(r_near, c_near);
    a_wr   = addr_of(RW'(in_cell_row), CW'(in_cell_col));
    wr_ok  = (XW'(in_cell_col) < XW'(MAX_COLS)) && (YW'(in_cell_row) < YW'(MAX_ROWS));

    push  = 1'b0;
    entry = '0;
    case (in_action)
      hbs_pkg::ACT_WRITE: begin
        push  = take && wr_ok;
        entry = {hbs_pkg::ACT_WRITE, in_cell_value, {3*AW{1'b0}}, a_wr, {4*WW{1'b0}}};
      end
      hbs_pkg::ACT_NEAREST: begin
        // One corner at full weight; the blend then returns it unchanged.
        push  = take;
        entry = {hbs_pkg::ACT_NEAREST, {hbs_pkg::DATA_W{1'b0}}, a_near, a_near, a_near,
                 a_near, {3*WW{1'b0}}, WW'(1 << (2*F))};
      end
      hbs_pkg::ACT_BILIN: begin
        push  = take;
        entry = {hbs_pkg::ACT_BILIN, {hbs_pkg::DATA_W{1'b0}}, a11, a01, a10, a00,
                 w11, w01, w10, w00};
      end
      default: begin
        push  = 1'b0;
        entry = '0;
      end
    endcase
  end

endmodule

// ----- sv/hbs_div.sv -----
// Restoring divider, one quotient bit per clock, for the normalised blend.
// Depends on hbs_pkg for the quotient width.
module hbs_div #(
  parameter int NW = 49,
  parameter int DW = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [NW-1:0]                num,
  input  logic [DW-1:0]                den,
  output logic                         busy,
  output logic                         done,
  output logic [hbs_pkg::DATA_W-1:0]   quot
);

  localparam int QW = hbs_pkg::DATA_W;
  localparam int KW = $clog2(QW+1);

  logic [DW-1:0] rem_r, den_r;
  logic [QW-1:0] q_r;
  logic [KW-1:0] cnt_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign busy  = (cnt_r != '0);
  assign done  = done_r;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      rem_r  <= '0;
      den_r  <= '0;
      q_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy) begin
        // The upper part of the numerator is below the divisor by construction.
        rem_r <= DW'(num[NW-1:QW]);
        q_r   <= num[QW-1:0];
        den_r <= den;
        cnt_r <= KW'(QW);
      end else if (busy) begin
        rem_r  <= ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
        q_r    <= {q_r[QW-2:0], ge};
        cnt_r  <= cnt_r - KW'(1);
        done_r <= (cnt_r == KW'(1));
      end
    end
  end

endmodule

// ----- sv/hbs_back.sv -----
// Back end: owns the height grid memory, reads the corners one per clock,
// accumulates the weighted sum and issues the result. Depends on hbs_pkg.
module hbs_back #(
  parameter int MAX_COLS  = hbs_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS  = hbs_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = hbs_pkg::DEF_FRAC_BITS,
  parameter int SENT_REGS = hbs_pkg::SENT_MAX
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_valid,
  input  logic [hbs_pkg::entry_w($clog2(MAX_COLS*MAX_ROWS), 2*FRAC_BITS+1)-1:0] q_entry,
  output logic                                     q_pop,
  input  logic [2:0]                               active,
  input  logic signed [hbs_pkg::DATA_W-1:0]        sentinel [SENT_REGS],
  output logic                                     div_start,
  output logic [2*FRAC_BITS+32:0]                  div_num,
  output logic [2*FRAC_BITS+1:0]                   div_den,
  input  logic                                     div_done,
  input  logic [hbs_pkg::DATA_W-1:0]               div_quot,
  output logic                                     out_valid,
  output logic signed [hbs_pkg::DATA_W-1:0]        out_sample_height
);

  localparam int F     = FRAC_BITS;
  localparam int AW    = $clog2(MAX_COLS*MAX_ROWS);
  localparam int WW    = 2*F+1;
  localparam int DEPTH = MAX_COLS*MAX_ROWS;
  localparam int DWD   = hbs_pkg::DATA_W;
  localparam int PRW   = DWD + WW + 1;
  localparam int SUMW  = PRW + 2;
  localparam int EXW   = SUMW + 2;
  localparam int NW    = 2*F+33;
  localparam int DW    = 2*F+2;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN, S_DIV} state_t;

  state_t                  state_r;
  logic [1:0]              kind_r;
  logic [AW-1:0]           addr_r [4];
  logic [WW-1:0]           wt_r [4];
  logic [2:0]              step_r;
  logic signed [DWD-1:0]   rd_r, h00_r;
  logic signed [PRW-1:0]   prod_r;
  logic                    pv_r;
  logic [WW-1:0]           pw_r;
  logic signed [SUMW-1:0]  sum_r;
  logic [WW-1:0]           tot_r;
  logic                    out_valid_r;
  logic signed [DWD-1:0]   out_r;

  logic [DWD-1:0]          mem [DEPTH];
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [1:0]              q_kind;
  logic [1:0]              cj;
  logic                    plain, nodata, need_div;
  logic signed [EXW-1:0]   num_x;
  logic signed [SUMW-1:0]  rnd;
  logic signed [DWD-1:0]   shift_res;

  assign q_kind  = q_entry[$bits(q_entry)-1 -: 2];
  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign mem_we  = q_pop && (q_kind == hbs_pkg::ACT_WRITE);
  assign rd_addr = addr_r[step_r[1:0]];
  assign cj      = 2'(step_r - 3'd1);
  assign plain   = (kind_r == hbs_pkg::ACT_NEAREST) || (active == 3'd0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_entry[4*WW+4*AW +: AW] == '0 ? q_entry[4*WW +: AW] : q_entry[4*WW +: AW]]
        <= q_entry[4*WW+4*AW +: DWD];
    end
    rd_r <= $signed(mem[rd_addr]);
  end

  always_comb begin
    nodata = (rd_r > hbs_pkg::NODATA_LIMIT);
    for (int i = 0; i < SENT_REGS; i++) begin
      if ((3'(i) < active) && (rd_r == sentinel[i])) nodata = 1'b1;
    end
  end

  always_comb begin
    need_div  = !plain && (tot_r != '0) && (tot_r != WW'(1 << (2*F)));
    num_x     = (EXW'(sum_r) <<< 1) + $signed(EXW'(tot_r)) + ($signed(EXW'(tot_r)) <<< 32);
    div_num   = num_x[NW-1:0];
    div_den   = {tot_r, 1'b0};
    div_start = (state_r == S_FIN) && need_div;
    rnd       = sum_r + (SUMW'(1) <<< (2*F-1));
    shift_res = rnd[2*F+DWD-1:2*F];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= hbs_pkg::ACT_WRITE;
      step_r      <= '0;
      pv_r        <= 1'b0;
      pw_r        <= '0;
      prod_r      <= '0;
      sum_r       <= '0;
      tot_r       <= '0;
      h00_r       <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        addr_r[i] <= '0;
        wt_r[i]   <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && (q_kind != hbs_pkg::ACT_WRITE)) begin
            kind_r <= q_kind;
            for (int i = 0; i < 4; i++) begin
              addr_r[i] <= q_entry[4*WW + i*AW +: AW];
              wt_r[i]   <= q_entry[i*WW +: WW];
            end
            step_r  <= '0;
            pv_r    <= 1'b0;
            sum_r   <= '0;
            tot_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          // Read corner k, weigh corner k-1, accumulate corner k-2.
          if (step_r >= 3'd1 && step_r <= 3'd4) begin
            prod_r <= rd_r * $signed({1'b0, wt_r[cj]});
            pv_r   <= plain || !nodata;
            pw_r   <= wt_r[cj];
            if (step_r == 3'd1) h00_r <= rd_r;
          end
          if (step_r >= 3'd2 && pv_r) begin
            sum_r <= sum_r + SUMW'(prod_r);
            tot_r <= tot_r + pw_r;
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd5) state_r <= S_FIN;
        end
        S_FIN: begin
          if (need_div) begin
            state_r <= S_DIV;
          end else begin
            out_valid_r <= 1'b1;
            out_r       <= (!plain && tot_r == '0) ? h00_r : shift_res;
            state_r     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            // The quotient carries an offset of 2^31 that keeps the divide unsigned.
            out_valid_r <= 1'b1;
            out_r       <= $signed({~div_quot[DWD-1], div_quot[DWD-2:0]});
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_height = out_r;

endmodule

// ----- sv/heightmap_bilinear_sampler_core.sv -----
// Top level of the heightmap bilinear sampler: configuration registers,
// front end, request queue, back end and divider. Depends on hbs_pkg.

// The block holds a height grid of MAX_COLS x MAX_ROWS signed Q24.8 cells and
// answers nearest and bilinear queries on it. A request is accepted at a
// rising edge where start is high and busy is low; busy rises only when the
// two-entry request queue is full. Writes give no result; each query gives
// exactly one result, shown for a single cycle with out_valid, in request
// order. The receiver cannot hold results back, so out_sample_height must be
// captured in the cycle that out_valid is high. The back end, which reads the
// one grid memory port once per clock, finishes a write when it fetches it
// from the queue. A query is fetched, goes through the four corner
// reads, the weighting multiply and the accumulate, and a finishing step. When
// sentinels are active and some, but not all, weighted corners are no-data,
// a normalising divide follows in the one-bit-per-clock divider. The grid is
// not cleared by reset: a cell must be written before it is read.
// Configuration must only be written while no request is in flight.
module heightmap_bilinear_sampler_core #(
  parameter int MAX_COLS       = hbs_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS       = hbs_pkg::DEF_MAX_ROWS,
  parameter int SENTINEL_SLOTS = hbs_pkg::DEF_SENTINEL_SLOTS,
  parameter int FRAC_BITS      = hbs_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_action,
  input  logic [hbs_pkg::CELL_IDX_W-1:0]       in_cell_col,
  input  logic [hbs_pkg::CELL_IDX_W-1:0]       in_cell_row,
  input  logic signed [hbs_pkg::DATA_W-1:0]    in_cell_value,
  input  logic signed [hbs_pkg::COORD_W-1:0]   in_col_coord,
  input  logic signed [hbs_pkg::COORD_W-1:0]   in_row_coord,
  output logic                                 out_valid,
  output logic signed [hbs_pkg::DATA_W-1:0]    out_sample_height,
  input  logic                                 cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hbs_pkg::DATA_W-1:0]           cfg_data
);

`include "heightmap_bilinear_sampler_core_macros.svh"

  localparam int WCW       = $clog2(MAX_COLS+1);
  localparam int WRW       = $clog2(MAX_ROWS+1);
  localparam int AW        = $clog2(MAX_COLS*MAX_ROWS);
  localparam int WW        = 2*FRAC_BITS+1;
  localparam int ENT_W     = hbs_pkg::entry_w(AW, WW);
  localparam int SENT_REGS = (SENTINEL_SLOTS < hbs_pkg::SENT_MAX) ? SENTINEL_SLOTS
                                                                  : hbs_pkg::SENT_MAX;
  localparam int QCW       = $clog2(hbs_pkg::QDEPTH+1);

  // Configuration registers.
  logic [8:0]                        grid_width_r, grid_height_r;
  logic [2:0]                        nodata_count_r;
  logic signed [hbs_pkg::DATA_W-1:0] sentinel_r [SENT_REGS];

  // Saturated view of the configuration.
  logic [WCW-1:0] eff_w;
  logic [WRW-1:0] eff_h;
  logic [2:0]     active;

  // Queue and back-end handshakes.
  logic             take, f_push, q_full, q_valid, q_pop;
  logic [ENT_W-1:0] f_entry, q_head;
  logic [QCW-1:0]   q_count;
  logic             div_start, div_busy, div_done;
  logic [2*FRAC_BITS+32:0]         div_num;
  logic [2*FRAC_BITS+1:0]          div_den;
  logic [hbs_pkg::DATA_W-1:0]      div_quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= 9'd256;
      grid_height_r  <= 9'd256;
      nodata_count_r <= 3'd0;
      for (int i = 0; i < SENT_REGS; i++) sentinel_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hbs_pkg::REG_GRID_WIDTH:   grid_width_r   <= cfg_data[8:0];
        hbs_pkg::REG_GRID_HEIGHT:  grid_height_r  <= cfg_data[8:0];
        hbs_pkg::REG_NODATA_COUNT: nodata_count_r <= cfg_data[2:0];
        default: begin
          // Sentinel slots beyond the configured number are simply absent.
          for (int i = 0; i < SENT_REGS; i++) begin
            if (cfg_index == hbs_pkg::CFG_IDX_W'(hbs_pkg::REG_NODATA_0 + i)) begin
              sentinel_r[i] <= $signed(cfg_data);
            end
          end
        end
      endcase
    end
  end

  // Sizes saturate to 1..MAX, and the sentinel count to the slots present.
  always_comb begin
    if (grid_width_r == '0)                  eff_w = WCW'(1);
    else if (32'(grid_width_r) > MAX_COLS)   eff_w = WCW'(MAX_COLS);
    else                                     eff_w = WCW'(grid_width_r);
    if (grid_height_r == '0)                 eff_h = WRW'(1);
    else if (32'(grid_height_r) > MAX_ROWS)  eff_h = WRW'(MAX_ROWS);
    else                                     eff_h = WRW'(grid_height_r);
    active = (nodata_count_r > 3'(SENT_REGS)) ? 3'(SENT_REGS) : nodata_count_r;
  end

  // The block refuses new requests only while the queue is full.
  assign busy = q_full;
  assign take = start && !q_full;

  hbs_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .take          (take),
    .in_action     (in_action),
    .in_cell_col   (in_cell_col),
    .in_cell_row   (in_cell_row),
    .in_cell_value (in_cell_value),
    .in_col_coord  (in_col_coord),
    .in_row_coord  (in_row_coord),
    .eff_w         (eff_w),
    .eff_h         (eff_h),
    .push          (f_push),
    .entry         (f_entry)
  );

  hbs_queue #(
    .WIDTH (ENT_W),
    .DEPTH (hbs_pkg::QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  hbs_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS),
    .SENT_REGS (SENT_REGS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_entry           (q_head),
    .q_pop             (q_pop),
    .active            (active),
    .sentinel          (sentinel_r),
    .div_start         (div_start),
    .div_num           (div_num),
    .div_den           (div_den),
    .div_done          (div_done),
    .div_quot          (div_quot),
    .out_valid         (out_valid),
    .out_sample_height (out_sample_height)
  );

  hbs_div #(
    .NW (2*FRAC_BITS+33),
    .DW (2*FRAC_BITS+2)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Every result needs at least a fetch and a corner pass, so strobes never abut.
  `HBS_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid, "two results in consecutive cycles")
  // The back end must only fetch from a queue that holds something.
  `HBS_ASSERT_ALWAYS(a_pop_nonempty, !q_pop || (q_count != '0), "fetch from empty queue")
  // A divide is only launched once the previous one has finished.
  `HBS_ASSERT_ALWAYS(a_div_free, !div_start || !div_busy, "divider started while busy")

endmodule

// ----- tb/sv/tb_heightmap_bilinear_sampler_core.sv -----
// Self-checking testbench for heightmap_bilinear_sampler_core.
// It holds its own predictor of the grid and of nearest and masked bilinear sampling.
// Depends on hbs_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_heightmap_bilinear_sampler_core;

  localparam int DATA_W     = hbs_pkg::DATA_W;
  localparam int COORD_W    = hbs_pkg::COORD_W;
  localparam int CELL_IDX_W = hbs_pkg::CELL_IDX_W;
  localparam int CFG_IDX_W  = hbs_pkg::CFG_IDX_W;
  localparam int SENT_MAX   = hbs_pkg::SENT_MAX;
  localparam logic signed [DATA_W-1:0] NODATA_LIMIT = hbs_pkg::NODATA_LIMIT;
  localparam logic [1:0] ACT_WRITE   = hbs_pkg::ACT_WRITE;
  localparam logic [1:0] ACT_NEAREST = hbs_pkg::ACT_NEAREST;
  localparam logic [1:0] ACT_BILIN   = hbs_pkg::ACT_BILIN;
  localparam logic [1:0] ACT_NONE    = hbs_pkg::ACT_NONE;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = hbs_pkg::REG_GRID_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = hbs_pkg::REG_GRID_HEIGHT;
  localparam logic [CFG_IDX_W-1:0] REG_NODATA_COUNT = hbs_pkg::REG_NODATA_COUNT;
  localparam logic [CFG_IDX_W-1:0] REG_NODATA_0     = hbs_pkg::REG_NODATA_0;

  localparam int GRID_COLS  = 256;
  localparam int FRAC       = 8;
  localparam int SETTLE     = 60;
  localparam int STALL_MAX  = 3000;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_action;
  logic [CELL_IDX_W-1:0]     in_cell_col;
  logic [CELL_IDX_W-1:0]     in_cell_row;
  logic signed [DATA_W-1:0]  in_cell_value;
  logic signed [COORD_W-1:0] in_col_coord;
  logic signed [COORD_W-1:0] in_row_coord;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_sample_height;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [DATA_W-1:0]         cfg_data;

  heightmap_bilinear_sampler_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_cell_col(in_cell_col), .in_cell_row(in_cell_row),
    .in_cell_value(in_cell_value), .in_col_coord(in_col_coord),
    .in_row_coord(in_row_coord), .out_valid(out_valid),
    .out_sample_height(out_sample_height), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the grid and of the configuration registers.
  logic signed [DATA_W-1:0] grid_shadow [0:65535];
  bit                       cell_written [0:65535];
  logic [8:0]               shadow_width;
  logic [8:0]               shadow_height;
  logic [2:0]               shadow_count;
  logic signed [DATA_W-1:0] shadow_sentinel [0:SENT_MAX-1];

  logic signed [DATA_W-1:0] pending_heights [$];
  int unsigned              error_count;
  int unsigned              idle_cycles;
  int                       burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register values outside 1..256 saturate into the usable range.
  function automatic int used_size(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > GRID_COLS) return GRID_COLS;
    return v;
  endfunction

  function automatic longint clamp_position(input longint p, input int size);
    longint top;
    top = longint'(size - 1) << FRAC;
    if (p < 0) return 0;
    if (p > top) return top;
    return p;
  endfunction

  function automatic longint div_floor(input longint n, input longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint height_at(input int r, input int c);
    return grid_shadow[r * GRID_COLS + c];
  endfunction

  // Above 50000 m, or equal to one of the active sentinels.
  function automatic bit is_masked(input longint hgt, input int active);
    if (hgt > NODATA_LIMIT) return 1'b1;
    for (int i = 0; i < active; i++)
      if (hgt == shadow_sentinel[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic signed [DATA_W-1:0] sample_height(
      input logic [1:0] act, input logic signed [COORD_W-1:0] cc,
      input logic signed [COORD_W-1:0] rc);
    int w, h, c0, r0, c1, r1, active;
    longint cp, rp, fx, fy, res, sum, tot, one;
    longint hv[4];
    longint wv[4];
    w = used_size(shadow_width);
    h = used_size(shadow_height);
    one = longint'(1) << FRAC;
    cp = clamp_position(longint'(cc), w);
    rp = clamp_position(longint'(rc), h);
    if (act == ACT_NEAREST) begin
      c0 = int'((cp + one / 2) >> FRAC);
      r0 = int'((rp + one / 2) >> FRAC);
      if (c0 > w - 1) c0 = w - 1;
      if (r0 > h - 1) r0 = h - 1;
      return height_at(r0, c0);
    end
    c0 = int'(cp >> FRAC);
    r0 = int'(rp >> FRAC);
    c1 = (c0 + 1 < w) ? c0 + 1 : w - 1;
    r1 = (r0 + 1 < h) ? r0 + 1 : h - 1;
    fx = cp & (one - 1);
    fy = rp & (one - 1);
    hv[0] = height_at(r0, c0);
    hv[1] = height_at(r0, c1);
    hv[2] = height_at(r1, c0);
    hv[3] = height_at(r1, c1);
    wv[0] = (one - fx) * (one - fy);
    wv[1] = fx * (one - fy);
    wv[2] = (one - fx) * fy;
    wv[3] = fx * fy;
    active = (shadow_count > SENT_MAX) ? SENT_MAX : shadow_count;
    sum = 0;
    tot = 0;
    for (int k = 0; k < 4; k++) begin
      if (active == 0 || !is_masked(hv[k], active)) begin
        sum += hv[k] * wv[k];
        tot += wv[k];
      end
    end
    // Plain blending divides by the full weight, which is the same rounding.
    if (tot <= 0) res = hv[0];
    else res = div_floor(2 * sum + tot, 2 * tot);
    return res[DATA_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Sends one request, updates the shadow state once it is accepted and then
  // may idle for a random gap whenever the current burst runs out.
  task automatic send_request(input logic [1:0] act, input logic [7:0] col,
      input logic [7:0] row, input logic signed [DATA_W-1:0] val,
      input logic signed [COORD_W-1:0] cc, input logic signed [COORD_W-1:0] rc);
    int gap;
    @(negedge clk);
    start         <= 1'b1;
    in_action     <= act;
    in_cell_col   <= col;
    in_cell_row   <= row;
    in_cell_value <= val;
    in_col_coord  <= cc;
    in_row_coord  <= rc;
    do @(posedge clk); while (busy);
    if (act == ACT_WRITE) begin
      grid_shadow[{row, col}]  = val;
      cell_written[{row, col}] = 1'b1;
    end else if (act != ACT_NONE) begin
      pending_heights.push_back(sample_height(act, cc, rc));
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic write_cell(input int r, input int c, input logic signed [DATA_W-1:0] v);
    send_request(ACT_WRITE, c[7:0], r[7:0], v, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic query(input logic [1:0] act, input longint cc, input longint rc);
    send_request(act, 8'($urandom), 8'($urandom), DATA_W'($urandom),
                 cc[COORD_W-1:0], rc[COORD_W-1:0]);
  endtask

  // Lowers start and waits until every queued query has answered, plus a
  // margin for a trailing write or divide.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_heights.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:   shadow_width  = v[8:0];
      REG_GRID_HEIGHT:  shadow_height = v[8:0];
      REG_NODATA_COUNT: shadow_count  = v[2:0];
      default: begin
        if (idx >= REG_NODATA_0 && idx < REG_NODATA_0 + SENT_MAX)
          shadow_sentinel[idx - REG_NODATA_0] = v;
      end
    endcase
  endtask

  // Heights drawn so that sentinels, the no-data limit and the extremes recur.
  function automatic logic signed [DATA_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: return shadow_sentinel[$urandom_range(0, SENT_MAX - 1)];
      1: return NODATA_LIMIT + $urandom_range(0, 1);
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return DATA_W'($urandom);
      default: return $signed($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  // Every cell that a query may read must hold a written value first.
  task automatic fill_area(input int w_reg, input int h_reg);
    int w, h;
    w = used_size(w_reg[8:0]);
    h = used_size(h_reg[8:0]);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (!cell_written[r * GRID_COLS + c]) write_cell(r, c, pick_height());
  endtask

  task automatic set_grid(input int w_reg, input int h_reg);
    drain();
    write_register(REG_GRID_WIDTH, w_reg);
    write_register(REG_GRID_HEIGHT, h_reg);
    fill_area(w_reg, h_reg);
  endtask

  // A position near or inside the grid, or now and then anywhere at all.
  function automatic longint pick_coord(input int size_reg);
    int size;
    size = used_size(size_reg[8:0]);
    if ($urandom_range(0, 7) == 0) return longint'($signed(COORD_W'($urandom)));
    return longint'($urandom_range(0, (size + 1) * 256)) - 128;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme heights and positions, half-up rounding and the unused action.
  task automatic test_plain_sampling();
    set_grid(4, 3);
    write_register(REG_NODATA_COUNT, 0);
    write_cell(0, 0, 32'sh7fffffff);
    write_cell(0, 1, 32'sh80000000);
    write_cell(1, 0, 32'sh80000000);
    write_cell(1, 1, 32'sh7fffffff);
    write_cell(255, 255, 32'sh12345678);
    query(ACT_NEAREST, 128, 128);
    query(ACT_NEAREST, 127, 383);
    query(ACT_NEAREST, -131072, -131072);
    query(ACT_NEAREST, 131071, 131071);
    query(ACT_BILIN, 128, 128);
    query(ACT_BILIN, 64, 200);
    query(ACT_BILIN, 3 * 256, 2 * 256);
    query(ACT_BILIN, 131071, -131072);
    send_request(ACT_NONE, 8'hff, 8'hff, 32'sh7fffffff, 18'sh1ffff, 18'sh20000);
    query(ACT_BILIN, 255, 1);
    // Hold off until every answer is back before going on.
    drain();
  endtask

  // Corners masked by value and by the height limit, partly and wholly.
  task automatic test_masking();
    set_grid(2, 2);
    write_register(REG_NODATA_COUNT, 4);
    write_register(REG_NODATA_0, 32'h80000000);
    write_register(CFG_IDX_W'(REG_NODATA_0 + 1), 32'h7fffffff);
    write_register(CFG_IDX_W'(REG_NODATA_0 + 2), 32'hffffff00);
    write_register(CFG_IDX_W'(REG_NODATA_0 + 3), 32'h00000500);
    write_cell(0, 0, 32'sh00000500);
    write_cell(0, 1, NODATA_LIMIT);
    write_cell(1, 0, NODATA_LIMIT + 1);
    write_cell(1, 1, 32'shffffff00);
    query(ACT_BILIN, 100, 100);
    query(ACT_NEAREST, 0, 0);
    write_cell(1, 1, 32'sh7fffffff);
    write_cell(0, 1, 32'sh80000000);
    query(ACT_BILIN, 77, 190);
    drain();
    // A count above the number of slots saturates.
    write_register(REG_NODATA_COUNT, 7);
    query(ACT_BILIN, 130, 20);
    write_cell(0, 0, 32'sh00001000);
    query(ACT_BILIN, 130, 20);
    drain();
    write_register(REG_NODATA_COUNT, 1);
    query(ACT_BILIN, 130, 20);
    drain();
  endtask

  // Single-row, single-column and out-of-range size settings.
  task automatic test_grid_sizes();
    int sizes [4][2] = '{'{256, 1}, '{1, 256}, '{0, 300}, '{511, 0}};
    foreach (sizes[i]) begin
      set_grid(sizes[i][0], sizes[i][1]);
      repeat (6) begin
        query(ACT_NEAREST, pick_coord(sizes[i][0]), pick_coord(sizes[i][1]));
        query(ACT_BILIN, pick_coord(sizes[i][0]), pick_coord(sizes[i][1]));
      end
    end
    drain();
  endtask

  // Random phases: a random configuration, then a mix of queries and writes.
  task automatic test_random_traffic();
    int w, h, pick;
    for (int phase = 0; phase < 8; phase++) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) % 40 : $urandom_range(1, 8);
      h = $urandom_range(0, 9);
      set_grid(w, h);
      write_register(REG_NODATA_COUNT, $urandom_range(0, 7));
      for (int i = 0; i < SENT_MAX; i++)
        write_register(CFG_IDX_W'(REG_NODATA_0 + i),
                       $urandom_range(0, 1) ? $urandom : pick_height());
      repeat (25) begin
        pick = $urandom_range(0, 19);
        if (pick < 6)
          write_cell($urandom_range(0, used_size(h) - 1), $urandom_range(0, used_size(w) - 1),
                     pick_height());
        else if (pick == 6)
          write_cell($urandom_range(0, 255), $urandom_range(0, 255), pick_height());
        else if (pick == 7)
          send_request(ACT_NONE, 8'($urandom), 8'($urandom), DATA_W'($urandom),
                       COORD_W'($urandom), COORD_W'($urandom));
        else if (pick < 11)
          query(ACT_NEAREST, pick_coord(w), pick_coord(h));
        else
          query(ACT_BILIN, pick_coord(w), pick_coord(h));
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] want,
      input logic signed [DATA_W-1:0] got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  // Results cannot be held back, so each one is captured on its only cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_heights.size() == 0) begin
        report_mismatch("unexpected result", 0, out_sample_height);
      end else begin
        if (out_sample_height !== pending_heights[0])
          report_mismatch("sample_height", pending_heights[0], out_sample_height);
        void'(pending_heights.pop_front());
      end
    end
  end

  // The run is stuck if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (pending_heights.size() != 0 || start) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = ACT_NONE;
    in_cell_col   = '0;
    in_cell_row   = '0;
    in_cell_value = '0;
    in_col_coord  = '0;
    in_row_coord  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    error_count   = 0;
    idle_cycles   = 0;
    burst_left    = 1;
    shadow_width  = 9'd256;
    shadow_height = 9'd256;
    shadow_count  = 3'd0;
    foreach (shadow_sentinel[i]) shadow_sentinel[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_sampling();
    test_masking();
    test_grid_sizes();
    test_random_traffic();

    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && pending_heights.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/hbs_pkg.sv
sv/hbs_queue.sv
sv/hbs_front.sv
sv/hbs_div.sv
sv/hbs_back.sv
sv/heightmap_bilinear_sampler_core.sv
tb/sv/tb_heightmap_bilinear_sampler_core.sv
